FILE: rtl/core/assert_macros.svh
// shared assertion macros for the scheduler core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked property, disabled while in reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/djs_pkg.sv
package djs_pkg;

    // input word: one job
    typedef struct packed {
        logic [15:0] job_deadline;
        logic [15:0] job_profit;
        logic        last_job;
    } t_job_in;

    // output word: one schedule summary
    typedef struct packed {
        logic [6:0]  jobs_taken;
        logic [21:0] total_profit;
        logic        overflow;
    } t_job_out;

    // operation broadcast to every store cell
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_POP
    } t_cell_op;

    // sequencer states
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_CMP,
        ST_UPD,
        ST_DONE
    } t_state;

    // true if job a ranks ahead of job b: higher profit, then earlier deadline
    function automatic logic goes_before(input logic [15:0] pa, input logic [15:0] da,
                                         input logic [15:0] pb, input logic [15:0] db);
        logic res;
        if (pa != pb) begin
            res = (pa > pb);
        end else begin
            res = (da < db);
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/djs_store_cell.sv
module djs_store_cell #(
    parameter int DW = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  djs_pkg::t_cell_op   i_op,
    input  logic [15:0]         i_new_profit,
    input  logic [DW-1:0]       i_new_deadline,
    input  logic                i_prev_keep,
    input  logic                i_prev_valid,
    input  logic [15:0]         i_prev_profit,
    input  logic [DW-1:0]       i_prev_deadline,
    input  logic                i_next_valid,
    input  logic [15:0]         i_next_profit,
    input  logic [DW-1:0]       i_next_deadline,
    output logic                o_valid,
    output logic [15:0]         o_profit,
    output logic [DW-1:0]       o_deadline,
    output logic                o_keep
);

    logic          r_valid, n_valid;
    logic [15:0]   r_profit, n_profit;
    logic [DW-1:0] r_deadline, n_deadline;

    // this cell stays put when its job ranks at or ahead of the new one
    assign o_keep = r_valid && !djs_pkg::goes_before(i_new_profit, 16'(i_new_deadline),
                                                     r_profit, 16'(r_deadline));

    // insert: keep, take new job, or take the one from above; pop: shift up
    always_comb begin
        n_valid    = r_valid;
        n_profit   = r_profit;
        n_deadline = r_deadline;
        unique case (i_op)
            djs_pkg::OP_INSERT: begin
                if (!o_keep) begin
                    if (i_prev_keep) begin
                        n_valid    = 1'b1;
                        n_profit   = i_new_profit;
                        n_deadline = i_new_deadline;
                    end else begin
                        n_valid    = i_prev_valid;
                        n_profit   = i_prev_profit;
                        n_deadline = i_prev_deadline;
                    end
                end
            end
            djs_pkg::OP_POP: begin
                n_valid    = i_next_valid;
                n_profit   = i_next_profit;
                n_deadline = i_next_deadline;
            end
            default: begin
            end
        endcase
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // job payload
    always_ff @(posedge i_clk) begin
        r_profit   <= n_profit;
        r_deadline <= n_deadline;
    end

    assign o_valid    = r_valid;
    assign o_profit   = r_profit;
    assign o_deadline = r_deadline;

endmodule

FILE: rtl/core/djs_slot_cell.sv
module djs_slot_cell #(
    parameter int SLOT = 1,
    parameter int DW   = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [DW-1:0] i_deadline,
    input  logic          i_cmp_en,
    input  logic          i_inc_en,
    input  logic          i_clear,
    output logic          o_ok
);

    // r_cnt: placed jobs whose deadline is at or below this slot
    logic [DW-1:0] r_cnt;
    logic          r_ok;
    logic          slot_covers;

    assign slot_covers = (i_deadline <= DW'(SLOT));

    // placed-job counter for this prefix of slots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_clear) begin
            r_cnt <= '0;
        end else if (i_inc_en && slot_covers) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // room check for the job under test: a free slot stays in this prefix
    always_ff @(posedge i_clk) begin
        if (i_cmp_en) begin
            r_ok <= !slot_covers || (r_cnt < DW'(SLOT));
        end
    end

    assign o_ok = r_ok;

endmodule

FILE: rtl/core/deadline_job_scheduler.sv
// Deadline job scheduler. Jobs (deadline, profit, last mark) are accepted one per
// cycle while the sequencer is loading, into a chain of MAX_JOBS store cells that
// keeps them ordered by descending profit, ties by ascending deadline; a job
// arriving on a full store is dropped and sets the overflow flag. After the word
// marked last, the sequencer pops the chain head and tests it against a row of
// MAX_JOBS slot cells, each counting the placed jobs whose deadline is at or below
// its slot: a job fits when every covering slot count is still below its slot
// number, which matches placing it in the latest free slot at or before its
// deadline. Each job of the pass first registers the per-slot room check, then
// reduces it and updates the counters; once the chain is empty the summary word is
// written. The summary sits in an output register; while it waits the block
// reloads, and only the end of the next pass waits for it to be taken. Counters and
// the store empty as part of the pass, so there is no clearing sweep after reset.
`include "assert_macros.svh"

module deadline_job_scheduler #(
    parameter int MAX_JOBS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  djs_pkg::t_job_in  i_job,
    output logic              o_valid,
    input  logic              i_ready,
    output djs_pkg::t_job_out o_result
);

    localparam int DW = $clog2(MAX_JOBS + 1);

    djs_pkg::t_state   r_state, n_state;
    djs_pkg::t_cell_op cell_op;

    logic [DW-1:0] r_count;
    logic          r_ovf;
    logic [DW-1:0] r_cur_d;
    logic [15:0]   r_cur_p;
    logic [DW-1:0] r_taken;
    logic [21:0]   r_total;
    logic          r_out_valid;
    djs_pkg::t_job_out r_out;

    logic          in_acc, out_acc;
    logic          store_full;
    logic [DW-1:0] new_d;
    logic          cmp_en, upd_en, fin_en, feasible;

    logic          c_valid    [MAX_JOBS];
    logic [15:0]   c_profit   [MAX_JOBS];
    logic [DW-1:0] c_deadline [MAX_JOBS];
    logic          c_keep     [MAX_JOBS];
    logic [MAX_JOBS-1:0] slot_ok;

    // handshakes
    assign o_ready    = (r_state == djs_pkg::ST_LOAD);
    assign in_acc     = i_valid && o_ready;
    assign out_acc    = r_out_valid && i_ready;
    assign store_full = (r_count == DW'(MAX_JOBS));

    // clamp deadline to the slot range
    assign new_d = (i_job.job_deadline > 16'(MAX_JOBS)) ? DW'(MAX_JOBS)
                                                        : i_job.job_deadline[DW-1:0];

    // placement decision from the registered room checks
    assign feasible = (r_cur_d != '0) && (&slot_ok);

    // sequencer next state and strobes
    always_comb begin
        n_state = r_state;
        cell_op = djs_pkg::OP_HOLD;
        cmp_en  = 1'b0;
        upd_en  = 1'b0;
        fin_en  = 1'b0;
        unique case (r_state)
            djs_pkg::ST_LOAD: begin
                if (in_acc) begin
                    if (!store_full) begin
                        cell_op = djs_pkg::OP_INSERT;
                    end
                    if (i_job.last_job) begin
                        n_state = djs_pkg::ST_CMP;
                    end
                end
            end
            djs_pkg::ST_CMP: begin
                if (c_valid[0]) begin
                    cell_op = djs_pkg::OP_POP;
                    cmp_en  = 1'b1;
                    n_state = djs_pkg::ST_UPD;
                end else begin
                    n_state = djs_pkg::ST_DONE;
                end
            end
            djs_pkg::ST_UPD: begin
                upd_en  = 1'b1;
                n_state = djs_pkg::ST_CMP;
            end
            djs_pkg::ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    fin_en  = 1'b1;
                    n_state = djs_pkg::ST_LOAD;
                end
            end
            default: begin
                n_state = djs_pkg::ST_LOAD;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= djs_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // set bookkeeping: stored count, overflow, running totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_taken <= '0;
            r_total <= '0;
        end else if (fin_en) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_taken <= '0;
            r_total <= '0;
        end else begin
            if (in_acc && store_full) begin
                r_ovf <= 1'b1;
            end
            if (in_acc && !store_full) begin
                r_count <= r_count + 1'b1;
            end
            if (upd_en && feasible) begin
                r_taken <= r_taken + 1'b1;
                r_total <= r_total + 22'(r_cur_p);
            end
        end
    end

    // job under test, taken from the chain head
    always_ff @(posedge i_clk) begin
        if (cmp_en) begin
            r_cur_d <= c_deadline[0];
            r_cur_p <= c_profit[0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_en) begin
            r_out_valid <= 1'b1;
        end else if (out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_en) begin
            r_out.jobs_taken   <= 7'(r_taken);
            r_out.total_profit <= r_total;
            r_out.overflow     <= r_ovf;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // sorted store chain
    for (genvar k = 0; k < MAX_JOBS; k++) begin : g_store
        logic          prev_keep, prev_valid, next_valid;
        logic [15:0]   prev_profit, next_profit;
        logic [DW-1:0] prev_deadline, next_deadline;

        if (k == 0) begin : g_head
            assign prev_keep     = 1'b1;
            assign prev_valid    = 1'b1;
            assign prev_profit   = i_job.job_profit;
            assign prev_deadline = new_d;
        end else begin : g_body
            assign prev_keep     = c_keep[k-1];
            assign prev_valid    = c_valid[k-1];
            assign prev_profit   = c_profit[k-1];
            assign prev_deadline = c_deadline[k-1];
        end

        if (k == MAX_JOBS - 1) begin : g_tail
            assign next_valid    = 1'b0;
            assign next_profit   = '0;
            assign next_deadline = '0;
        end else begin : g_mid
            assign next_valid    = c_valid[k+1];
            assign next_profit   = c_profit[k+1];
            assign next_deadline = c_deadline[k+1];
        end

        djs_store_cell #(
            .DW (DW)
        ) u_cell (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_op            (cell_op),
            .i_new_profit    (i_job.job_profit),
            .i_new_deadline  (new_d),
            .i_prev_keep     (prev_keep),
            .i_prev_valid    (prev_valid),
            .i_prev_profit   (prev_profit),
            .i_prev_deadline (prev_deadline),
            .i_next_valid    (next_valid),
            .i_next_profit   (next_profit),
            .i_next_deadline (next_deadline),
            .o_valid         (c_valid[k]),
            .o_profit        (c_profit[k]),
            .o_deadline      (c_deadline[k]),
            .o_keep          (c_keep[k])
        );
    end

    // slot counter row, slots 1 to MAX_JOBS
    for (genvar s = 0; s < MAX_JOBS; s++) begin : g_slot
        djs_slot_cell #(
            .SLOT (s + 1),
            .DW   (DW)
        ) u_slot (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_deadline (cmp_en ? c_deadline[0] : r_cur_d),
            .i_cmp_en   (cmp_en),
            .i_inc_en   (upd_en && feasible),
            .i_clear    (fin_en),
            .o_ok       (slot_ok[s])
        );
    end

    // chain head never ranks behind its neighbor
    `ASSERT_IMP(a_head_sorted, i_clk, i_rst_n, c_valid[0] && c_valid[1], !djs_pkg::goes_before(c_profit[1], 16'(c_deadline[1]), c_profit[0], 16'(c_deadline[0])), "store chain out of order")

    // no more jobs placed than stored
    `ASSERT_CLK(a_taken_bound, i_clk, i_rst_n, r_taken <= r_count, "placed count exceeds stored count")

    // a last word stops intake until the summary is produced
    `ASSERT_NEXT(a_last_blocks, i_clk, i_rst_n, in_acc && i_job.last_job, !o_ready, "intake open during scheduling pass")

    // a pending summary is not lost before it is taken
    `ASSERT_NEXT(a_out_held, i_clk, i_rst_n, r_out_valid && !i_ready, r_out_valid && $stable(r_out), "pending summary changed")

endmodule

FILE: tb/sv/tb_deadline_job_scheduler.sv
`timescale 1ns / 100ps

module tb_deadline_job_scheduler;

    localparam int SCHED_DEPTH  = 64;
    localparam int IDLE_PERCENT = 35;
    localparam int HOLD_CYCLES  = 500;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    djs_pkg::t_job_in  i_job = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    djs_pkg::t_job_out o_result;

    // shadow of the sorted job store and the slot map
    logic [15:0] held_profit [SCHED_DEPTH];
    logic [15:0] held_deadline [SCHED_DEPTH];
    int unsigned held_count = 0;
    bit          overflow_pending = 1'b0;
    bit          slot_used [SCHED_DEPTH + 1];

    // summaries predicted but not yet seen on the output
    djs_pkg::t_job_out summary_q[$];

    bit          idle_en = 1'b1;
    // toggled by the sender to ask for a hold-off, followed by the receiver process
    bit          ready_hold_req = 1'b0;
    bit          hold_seen = 1'b0;
    int unsigned hold_left = 0;
    int unsigned error_count = 0;
    int unsigned jobs_sent = 0;
    int unsigned summaries_checked = 0;
    int unsigned overflow_sets = 0;

    deadline_job_scheduler #(
        .MAX_JOBS(SCHED_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_job   (i_job),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_result(o_result)
    );

    always #5 i_clk = ~i_clk;

    // predict: sorted insert, and on the last job the greedy slot pass
    function automatic void absorb_job(input djs_pkg::t_job_in j);
        int unsigned d;
        int unsigned pos;
        int unsigned s;
        logic [6:0]  taken;
        logic [21:0] total;
        djs_pkg::t_job_out r;
        d = (j.job_deadline > SCHED_DEPTH) ? SCHED_DEPTH : 32'(j.job_deadline);
        if (held_count >= SCHED_DEPTH) begin
            overflow_pending = 1'b1;
        end else begin
            pos = held_count;
            // higher profit first, equal profit by earlier deadline, equal keys keep arrival order
            while (pos > 0 && ((j.job_profit > held_profit[pos-1]) ||
                   (j.job_profit == held_profit[pos-1] && d < held_deadline[pos-1]))) begin
                held_profit[pos]   = held_profit[pos-1];
                held_deadline[pos] = held_deadline[pos-1];
                pos--;
            end
            held_profit[pos]   = j.job_profit;
            held_deadline[pos] = 16'(d);
            held_count++;
        end
        if (!j.last_job) begin
            return;
        end
        taken = '0;
        total = '0;
        for (int unsigned i = 0; i < held_count; i++) begin
            s = 32'(held_deadline[i]);
            while (s >= 1 && slot_used[s]) begin
                s--;
            end
            if (s >= 1) begin
                slot_used[s] = 1'b1;
                taken = taken + 7'd1;
                total = total + 22'(held_profit[i]);
            end
        end
        r.jobs_taken   = taken;
        r.total_profit = total;
        r.overflow     = overflow_pending;
        summary_q.insert(summary_q.size(), r);
        if (overflow_pending) begin
            overflow_sets++;
        end
        for (int i = 0; i <= SCHED_DEPTH; i++) begin
            slot_used[i] = 1'b0;
        end
        held_count = 0;
        overflow_pending = 1'b0;
    endfunction

    // send one job word, with random idle cycles ahead of it
    task automatic send_job(input logic [15:0] d, input logic [15:0] p, input logic last);
        djs_pkg::t_job_in j;
        j.job_deadline = d;
        j.job_profit   = p;
        j.last_job     = last;
        while (idle_en && $urandom_range(99) < IDLE_PERCENT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_job   <= j;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        absorb_job(j);
        jobs_sent++;
    endtask

    function automatic logic [15:0] rand_deadline(input int unsigned len);
        logic [15:0] d;
        case ($urandom_range(9)) inside
            0: d = 16'd0;
            [1:5]: d = 16'($urandom_range(1, len + 2));
            [6:7]: d = 16'($urandom_range(1, SCHED_DEPTH));
            8: d = 16'($urandom_range(SCHED_DEPTH + 1, 65535));
            default: d = 16'($urandom);
        endcase
        return d;
    endfunction

    function automatic logic [15:0] rand_profit();
        logic [15:0] p;
        case ($urandom_range(9)) inside
            0: p = 16'd0;
            1: p = 16'hFFFF;
            [2:4]: p = 16'($urandom_range(0, 7));
            default: p = 16'($urandom);
        endcase
        return p;
    endfunction

    // one complete set of random jobs, mostly short, now and then over capacity
    task automatic send_random_set();
        int unsigned len;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 70) begin
            len = $urandom_range(1, 8);
        end else if (pick < 90) begin
            len = $urandom_range(9, 32);
        end else if (pick < 97) begin
            len = $urandom_range(33, SCHED_DEPTH);
        end else begin
            len = $urandom_range(SCHED_DEPTH + 1, SCHED_DEPTH + 8);
        end
        for (int unsigned k = 1; k <= len; k++) begin
            send_job(rand_deadline(len), rand_profit(), k == len);
        end
    endtask

    // hold the sender until every predicted summary has been seen
    task automatic wait_for_summaries();
        i_valid <= 1'b0;
        while (summary_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat ($urandom_range(5, 30)) @(posedge i_clk);
    endtask

    // output side: random ready, or a long hold-off on request
    always @(posedge i_clk) begin
        if (ready_hold_req != hold_seen) begin
            hold_seen <= ready_hold_req;
            hold_left <= HOLD_CYCLES;
            i_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready <= 1'b0;
        end else if (idle_en) begin
            i_ready <= ($urandom_range(99) >= IDLE_PERCENT);
        end else begin
            i_ready <= 1'b1;
        end
    end

    // compare each accepted summary word with the oldest prediction
    always @(posedge i_clk) begin
        djs_pkg::t_job_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (summary_q.size() == 0) begin
                $error("unexpected summary word: jobs_taken %0d total_profit %0d overflow %0d",
                       o_result.jobs_taken, o_result.total_profit, o_result.overflow);
                error_count++;
            end else begin
                want = summary_q.pop_front();
                summaries_checked++;
                if (o_result.jobs_taken !== want.jobs_taken) begin
                    $error("jobs_taken: expected %0d, got %0d",
                           want.jobs_taken, o_result.jobs_taken);
                    error_count++;
                end
                if (o_result.total_profit !== want.total_profit) begin
                    $error("total_profit: expected %0d, got %0d",
                           want.total_profit, o_result.total_profit);
                    error_count++;
                end
                if (o_result.overflow !== want.overflow) begin
                    $error("overflow: expected %0d, got %0d",
                           want.overflow, o_result.overflow);
                    error_count++;
                end
            end
        end
    end

    // zero and huge deadlines, extreme profits, ties, alternating bit patterns
    task automatic test_directed_cases();
        send_job(16'd0, 16'd500, 1'b1);
        send_job(16'd1, 16'hFFFF, 1'b1);
        send_job(16'hFFFF, 16'd0, 1'b1);
        send_job(16'd2, 16'd100, 1'b0);
        send_job(16'd2, 16'd100, 1'b0);
        send_job(16'd2, 16'd100, 1'b0);
        send_job(16'd1, 16'd100, 1'b0);
        send_job(16'd3, 16'd40, 1'b0);
        send_job(16'd0, 16'hFFFF, 1'b1);
        send_job(16'd64, 16'd7, 1'b0);
        send_job(16'd100, 16'd9, 1'b0);
        send_job(16'hFFFF, 16'd5, 1'b0);
        send_job(16'd1, 16'd3, 1'b0);
        send_job(16'h8000, 16'd1, 1'b1);
        send_job(16'hAAAA, 16'h5555, 1'b0);
        send_job(16'h5555, 16'hAAAA, 1'b1);
    endtask

    // full store: top profit everywhere, a dropped last job, then an overfull random set of SCHED_DEPTH + 3 jobs
    task automatic test_store_full();
        for (int k = 0; k < SCHED_DEPTH; k++) begin
            send_job(16'hFFFF, 16'hFFFF, 1'b0);
        end
        send_job(16'd1, 16'd1, 1'b1);
        for (int k = 0; k < SCHED_DEPTH + 3; k++) begin
            send_job(rand_deadline(SCHED_DEPTH), rand_profit(), k == SCHED_DEPTH + 2);
        end
    endtask

    // receiver stalls long enough to back up the block, then drain fully
    task automatic test_back_pressure();
        ready_hold_req = !ready_hold_req;
        repeat (4) send_random_set();
        wait_for_summaries();
    endtask

    task automatic test_random_sets(input int unsigned n_jobs, input bit with_idles);
        int unsigned stop_at;
        idle_en = with_idles;
        stop_at = jobs_sent + n_jobs;
        while (jobs_sent < stop_at) begin
            send_random_set();
        end
        idle_en = 1'b1;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_store_full();
        test_back_pressure();
        test_random_sets(450, 1'b1);
        test_random_sets(250, 1'b0);
        test_random_sets(400, 1'b1);
        i_valid <= 1'b0;
        while (summary_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (200) @(posedge i_clk);
        $display("sent %0d job words, checked %0d schedule summaries (%0d with store overflow)",
                 jobs_sent, summaries_checked, overflow_sets);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("timeout with %0d summaries outstanding", summary_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
